// ===== rtl/stt_pkg.sv =====
// Shared types and constants for the system tick timer.
`timescale 1ns / 1ps

package stt_pkg;

  // Default build values
  localparam int unsigned DefCounterWidth    = 24;
  localparam int unsigned DefPrescaleDivisor = 8;

  // Control register bit positions
  localparam int unsigned CtrlEnableBit = 0;
  localparam int unsigned CtrlIntBit    = 1;
  localparam int unsigned CtrlClksrcBit = 2;
  localparam int unsigned CtrlFlagPos   = 16;

  // Request kinds
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } stt_op_e;

  // Register map
  typedef enum logic [1:0] {
    REG_CTRL    = 2'd0,
    REG_RELOAD  = 2'd1,
    REG_VALUE   = 2'd2,
    REG_ELAPSED = 2'd3
  } stt_reg_e;

  typedef struct packed {
    stt_op_e     op;
    stt_reg_e    reg_index;
    logic [31:0] write_data;
  } stt_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_pulse;
    logic        running;
  } stt_rsp_t;

endpackage

// ===== rtl/stt_engine.sv =====
// Timer state and single-pass request processing for the system tick timer.
`timescale 1ns / 1ps

module stt_engine #(
  parameter int unsigned COUNTER_WIDTH    = stt_pkg::DefCounterWidth,
  parameter int unsigned PRESCALE_DIVISOR = stt_pkg::DefPrescaleDivisor
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             one_shot_i,
  input  logic             step_i,
  input  stt_pkg::stt_req_t req_i,
  output stt_pkg::stt_rsp_t rsp_o
);
  import stt_pkg::*;

  localparam int unsigned PsWidth = $clog2(PRESCALE_DIVISOR);
  localparam logic [PsWidth-1:0] PsLast = PsWidth'(PRESCALE_DIVISOR - 1);

  logic                     en_q, en_d;
  logic                     ie_q, ie_d;
  logic                     fr_q, fr_d;
  logic                     flag_q, flag_d;
  logic [COUNTER_WIDTH-1:0] reload_q, reload_d;
  logic [COUNTER_WIDTH-1:0] cur_q, cur_d;
  logic [PsWidth-1:0]       ps_q, ps_d;
  logic [COUNTER_WIDTH-1:0] cur_dec;
  logic                     count_now;
  logic                     expire;

  // Decide whether this tick reaches the down counter
  assign count_now = en_q && (fr_q || (ps_q == PsLast));
  assign cur_dec   = cur_q - COUNTER_WIDTH'(1);
  assign expire    = (req_i.op == OP_TICK) && count_now &&
                     (cur_q != '0) && (cur_dec == '0);

  // Apply one request to the timer state and form its response
  always_comb begin
    en_d     = en_q;
    ie_d     = ie_q;
    fr_d     = fr_q;
    flag_d   = flag_q;
    reload_d = reload_q;
    cur_d    = cur_q;
    ps_d     = ps_q;
    rsp_o.read_data = '0;
    rsp_o.irq_pulse = 1'b0;

    case (req_i.op)
      OP_TICK: begin
        if (en_q) begin
          if (!fr_q) begin
            ps_d = (ps_q == PsLast) ? '0 : ps_q + PsWidth'(1);
          end
          if (count_now) begin
            if (cur_q == '0) begin
              cur_d = reload_q;
            end else if (cur_dec != '0) begin
              cur_d = cur_dec;
            end else begin
              cur_d           = '0;
              flag_d          = 1'b1;
              rsp_o.irq_pulse = ie_q;
              if (one_shot_i) begin
                en_d     = 1'b0;
                ie_d     = 1'b0;
                reload_d = '0;
              end
            end
          end
        end
      end
      OP_READ: begin
        unique case (req_i.reg_index)
          REG_CTRL: begin
            rsp_o.read_data[CtrlEnableBit] = en_q;
            rsp_o.read_data[CtrlIntBit]    = ie_q;
            rsp_o.read_data[CtrlClksrcBit] = fr_q;
            rsp_o.read_data[CtrlFlagPos]   = flag_q;
            flag_d = 1'b0;
          end
          REG_RELOAD:  rsp_o.read_data = 32'(reload_q);
          REG_VALUE:   rsp_o.read_data = 32'(cur_q);
          REG_ELAPSED: rsp_o.read_data = 32'(reload_q) - 32'(cur_q);
          default:     rsp_o.read_data = '0;
        endcase
      end
      OP_WRITE: begin
        unique case (req_i.reg_index)
          REG_CTRL: begin
            en_d = req_i.write_data[CtrlEnableBit];
            ie_d = req_i.write_data[CtrlIntBit];
            fr_d = req_i.write_data[CtrlClksrcBit];
          end
          REG_RELOAD: reload_d = req_i.write_data[COUNTER_WIDTH-1:0];
          REG_VALUE: begin
            cur_d  = '0;
            flag_d = 1'b0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    rsp_o.running = en_d;
  end

  // Commit state only when a request advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= 1'b0;
      ie_q     <= 1'b0;
      fr_q     <= 1'b0;
      flag_q   <= 1'b0;
      reload_q <= '0;
      cur_q    <= '0;
      ps_q     <= '0;
    end else if (step_i) begin
      en_q     <= en_d;
      ie_q     <= ie_d;
      fr_q     <= fr_d;
      flag_q   <= flag_d;
      reload_q <= reload_d;
      cur_q    <= cur_d;
      ps_q     <= ps_d;
    end
  end

  // An interrupt pulse needs the interrupt enabled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.irq_pulse |-> ie_q)
    else $error("irq pulse without interrupt enable");

  // One-shot expiry stops and clears the counter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && expire && one_shot_i) |=> (!en_q && !ie_q && reload_q == '0 && cur_q == '0))
    else $error("one-shot expiry did not stop the timer");

  // Expiry always raises the count flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && expire) |=> flag_q)
    else $error("expiry did not set the count flag");

  // State holds while no request advances
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> ($stable(cur_q) && $stable(en_q) && $stable(ps_q)))
    else $error("timer state changed without a request");

  // Prescaler stays within its divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ps_q <= PsLast)
    else $error("prescaler out of range");

endmodule

// ===== rtl/system_tick_timer_core.sv =====
// Top level of the system tick timer: stream channels, request and result registers.
`timescale 1ns / 1ps
//
// Down-counting tick timer with control, reload, current value and elapsed
// registers. Every request on the slave stream is a clock tick, a register
// read or a register write (tuser: op, then register index); tdata carries
// the write data. Every request gives exactly one result on the master
// stream: read data in tdata[31:0], the interrupt pulse at bit 32 and the
// counter enable at bit 33.
// A request is held in the request register, is processed in one pass and
// lands in the result register. One request is accepted every cycle while
// the result side drains; the single result register sets that rate.
// When the receiver stalls, the result holds and the request register
// fills; tready then drops until the result is taken.
// The one-shot mode bit is written through cfg_we_i / cfg_wdata_i; the user
// must do so only while no request is in flight (not enforced here). Reset
// clears all timer state, the mode bit and the valid bits of both registers.
//
module system_tick_timer_core #(
  parameter int unsigned COUNTER_WIDTH    = stt_pkg::DefCounterWidth,
  parameter int unsigned PRESCALE_DIVISOR = stt_pkg::DefPrescaleDivisor
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,      // one_shot_mode
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] write_data
  input  logic [3:0]  s_axis_tuser_i,   // [1:0] op, [3:2] reg_index
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // [31:0] read_data, [32] irq_pulse, [33] running
);
  import stt_pkg::*;

  logic     one_shot_q;
  logic     in_valid_q;
  stt_req_t req_q;
  logic     out_valid_q;
  stt_rsp_t rsp_q;
  stt_rsp_t rsp;
  logic     advance;
  logic     s_accept;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  // Hold the mode bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_shot_q <= 1'b0;
    end else if (cfg_we_i) begin
      one_shot_q <= cfg_wdata_i;
    end
  end

  // Capture the incoming request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      req_q.op         <= stt_op_e'(s_axis_tuser_i[1:0]);
      req_q.reg_index  <= stt_reg_e'(s_axis_tuser_i[3:2]);
      req_q.write_data <= s_axis_tdata_i;
    end
  end

  stt_engine #(
    .COUNTER_WIDTH    (COUNTER_WIDTH),
    .PRESCALE_DIVISOR (PRESCALE_DIVISOR)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .one_shot_i (one_shot_q),
    .step_i     (advance),
    .req_i      (req_q),
    .rsp_o      (rsp)
  );

  // Load the result register, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= rsp;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, rsp_q.running, rsp_q.irq_pulse, rsp_q.read_data};

  // A waiting request is never lost while the result side stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(req_q)))
    else $error("pending request lost");

  // A stalled result is not overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !advance)
    else $error("result overwritten while stalled");

  // Acceptance with a full request register only when it drains
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && in_valid_q) |-> advance)
    else $error("request accepted over a held request");

endmodule
